>>> rtl/core/ntl_pkg.sv
// Shared types and constants for the nibble trie route lookup.
// Used by ntl_front, ntl_back and the top level; no dependencies.
`timescale 1ns / 1ps
package ntl_pkg;

  localparam int unsigned AddrW  = 128;
  localparam int unsigned HopW   = 8;
  localparam int unsigned LenW   = 8;
  localparam int unsigned MaxLen = 128;
  localparam int unsigned Levels = 32;
  localparam int unsigned Fanout = 16;
  localparam int unsigned LevelW = 6;

  localparam logic OpInsert = 1'b0;
  localparam logic OpLookup = 1'b1;

  typedef struct packed {
    logic              lookup;
    logic              zero_len;
    logic [LevelW-1:0] steps;
    logic [AddrW-1:0]  addr;
    logic [HopW-1:0]   hop;
  } cmd_t;

endpackage

>>> rtl/core/ntl_front.sv
// Front end: accepts input beats, classifies them into commands and queues them.
// Depends on ntl_pkg.
`timescale 1ns / 1ps
module ntl_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    op_i,
  input  logic [63:0]             addr_high_i,
  input  logic [63:0]             addr_low_i,
  input  logic [ntl_pkg::LenW-1:0] prefix_len_i,
  input  logic [ntl_pkg::HopW-1:0] hop_in_i,
  output logic                    cmd_valid_o,
  output ntl_pkg::cmd_t           cmd_o,
  input  logic                    cmd_pop_i
);

  ntl_pkg::cmd_t     slot_q [2];
  logic              rd_ptr_q, rd_ptr_d;
  logic              wr_ptr_q, wr_ptr_d;
  logic [1:0]        count_q, count_d;
  logic              push;
  logic              pop;
  logic [ntl_pkg::LenW-1:0] len_clamp;
  logic [ntl_pkg::LenW:0]   len_round;
  ntl_pkg::cmd_t     cmd_new;

  always_comb begin
    len_clamp = (prefix_len_i > ntl_pkg::LenW'(ntl_pkg::MaxLen)) ?
                ntl_pkg::LenW'(ntl_pkg::MaxLen) : prefix_len_i;
    len_round = {1'b0, len_clamp} + (ntl_pkg::LenW+1)'(3);
    cmd_new.lookup   = (op_i == ntl_pkg::OpLookup);
    cmd_new.zero_len = (op_i == ntl_pkg::OpInsert) && (len_clamp == '0);
    cmd_new.steps    = len_round[ntl_pkg::LevelW+1:2];
    cmd_new.addr     = {addr_high_i, addr_low_i};
    cmd_new.hop      = hop_in_i;
  end

  assign in_stall_o  = (count_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = slot_q[rd_ptr_q];

  always_comb begin
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

>>> rtl/core/ntl_back.sv
// Back end: walks the node pool memory for inserts and lookups, holds the result beat.
// Depends on ntl_pkg.
`timescale 1ns / 1ps
module ntl_back #(
  parameter int unsigned NODE_COUNT = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_valid_i,
  input  ntl_pkg::cmd_t            cmd_i,
  output logic                     cmd_pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     found_o,
  output logic [ntl_pkg::HopW-1:0] hop_out_o,
  output logic                     pool_full_o,
  output logic [$clog2(NODE_COUNT):0] used_o
);

  localparam int unsigned IW    = $clog2(NODE_COUNT);
  localparam int unsigned ROW_W = ntl_pkg::Fanout * IW + ntl_pkg::HopW + 1;
  localparam int unsigned VLD_B = ROW_W - 1;
  localparam int unsigned HOP_L = ntl_pkg::Fanout * IW;

  localparam logic [2:0] StClr  = 3'd0;
  localparam logic [2:0] StIdle = 3'd1;
  localparam logic [2:0] StRd   = 3'd2;
  localparam logic [2:0] StEx   = 3'd3;
  localparam logic [2:0] StNew  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [ROW_W-1:0] mem [NODE_COUNT];
  logic [ROW_W-1:0] rdata_q;
  logic             we;
  logic [ROW_W-1:0] wdata;

  logic [2:0]                  state_q, state_d;
  ntl_pkg::cmd_t               cmd_q, cmd_d;
  logic [IW-1:0]               cur_q, cur_d;
  logic [ntl_pkg::LevelW-1:0]  lvl_q, lvl_d;
  logic [IW:0]                 used_q, used_d;
  logic                        hit_q, hit_d;
  logic [ntl_pkg::HopW-1:0]    best_q, best_d;
  logic                        full_q, full_d;
  logic                        out_valid_q, out_valid_d;
  logic                        found_q, found_d;
  logic [ntl_pkg::HopW-1:0]    hop_q, hop_d;
  logic                        pfull_q, pfull_d;
  logic [3:0]                  nib;
  logic [IW-1:0]               child;
  logic                        row_vld;

  assign nib     = cmd_q.addr[{~lvl_q[4:0], 2'b00} +: 4];
  assign child   = rdata_q[nib * IW +: IW];
  assign row_vld = rdata_q[VLD_B];

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cur_d       = cur_q;
    lvl_d       = lvl_q;
    used_d      = used_q;
    hit_d       = hit_q;
    best_d      = best_q;
    full_d      = full_q;
    out_valid_d = out_valid_q && out_stall_i;
    found_d     = found_q;
    hop_d       = hop_q;
    pfull_d     = pfull_q;
    cmd_pop_o   = 1'b0;
    we          = 1'b0;
    wdata       = rdata_q;
    case (state_q)
      StClr: begin
        we      = 1'b1;
        wdata   = '0;
        state_d = StIdle;
      end
      StIdle: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          cur_d     = '0;
          lvl_d     = '0;
          hit_d     = 1'b0;
          best_d    = '0;
          full_d    = 1'b0;
          state_d   = StRd;
        end
      end
      StRd: begin
        state_d = StEx;
      end
      StEx: begin
        if (cmd_q.lookup) begin
          if (row_vld) begin
            hit_d  = 1'b1;
            best_d = rdata_q[HOP_L +: ntl_pkg::HopW];
          end
          if (lvl_q == ntl_pkg::LevelW'(ntl_pkg::Levels) || child == '0) begin
            state_d = StOut;
          end else begin
            cur_d   = child;
            lvl_d   = lvl_q + 1'b1;
            state_d = StRd;
          end
        end else if (lvl_q == cmd_q.steps) begin
          if (cmd_q.zero_len || !row_vld) begin
            we                            = 1'b1;
            wdata[VLD_B]                  = 1'b1;
            wdata[HOP_L +: ntl_pkg::HopW] = cmd_q.hop;
          end
          state_d = StOut;
        end else if (child != '0) begin
          cur_d   = child;
          lvl_d   = lvl_q + 1'b1;
          state_d = StRd;
        end else if (used_q == (IW+1)'(NODE_COUNT)) begin
          full_d  = 1'b1;
          state_d = StOut;
        end else begin
          we                   = 1'b1;
          wdata[nib * IW +: IW] = used_q[IW-1:0];
          cur_d                = used_q[IW-1:0];
          used_d               = used_q + 1'b1;
          lvl_d                = lvl_q + 1'b1;
          state_d              = StNew;
        end
      end
      StNew: begin
        we      = 1'b1;
        wdata   = '0;
        state_d = StRd;
      end
      StOut: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          found_d     = cmd_q.lookup && hit_q;
          hop_d       = (cmd_q.lookup && hit_q) ? best_q : '0;
          pfull_d     = !cmd_q.lookup && full_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClr;
      cur_q       <= '0;
      used_q      <= (IW+1)'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    lvl_q   <= lvl_d;
    hit_q   <= hit_d;
    best_q  <= best_d;
    full_q  <= full_d;
    found_q <= found_d;
    hop_q   <= hop_d;
    pfull_q <= pfull_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[cur_q] <= wdata;
    end
    rdata_q <= mem[cur_d];
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign hop_out_o   = hop_q;
  assign pool_full_o = pfull_q;
  assign used_o      = used_q;

endmodule

>>> rtl/core/ipv6_nibble_trie_lookup.sv
// IPv6 longest prefix match over a 4-bit stride trie: top level.
// Depends on ntl_pkg, ntl_front and ntl_back.
`timescale 1ns / 1ps
// Route table of NODE_COUNT trie nodes, one memory row per node holding its
// sixteen child links and optional next hop; node 0 is the root. Items are
// queued two deep by the front end and executed one at a time by the back end.
// Each trie level takes a registered row read, then a decision; a newly
// allocated node adds a step that clears its row. Each item also has a
// command pop before the walk and a result register after it. After reset
// the root row is cleared before the first item is taken.
module ipv6_nibble_trie_lookup #(
  parameter int unsigned NODE_COUNT = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     op_i,
  input  logic [63:0]              addr_high_i,
  input  logic [63:0]              addr_low_i,
  input  logic [ntl_pkg::LenW-1:0] prefix_len_i,
  input  logic [ntl_pkg::HopW-1:0] hop_in_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     found_o,
  output logic [ntl_pkg::HopW-1:0] hop_out_o,
  output logic                     pool_full_o
);

  logic                        cmd_valid;
  ntl_pkg::cmd_t               cmd;
  logic                        cmd_pop;
  logic [$clog2(NODE_COUNT):0] used;

  ntl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .addr_high_i  (addr_high_i),
    .addr_low_i   (addr_low_i),
    .prefix_len_i (prefix_len_i),
    .hop_in_i     (hop_in_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  ntl_back #(
    .NODE_COUNT (NODE_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .found_o     (found_o),
    .hop_out_o   (hop_out_o),
    .pool_full_o (pool_full_o),
    .used_o      (used)
  );

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used <= ($clog2(NODE_COUNT)+1)'(NODE_COUNT) && used != '0)
    else $error("node count out of range");

  a_used_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> used >= $past(used))
    else $error("node count decreased");

  a_found_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> !pool_full_o)
    else $error("lookup hit flagged pool full");

  a_miss_hop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> hop_out_o == '0)
    else $error("nonzero hop without a match");

endmodule
